// ===== design/sbc_pkg.sv =====
`default_nettype none
package sbc_pkg;

    localparam int unsigned MIX_ROUNDS = 262144;
    localparam int unsigned RW = $clog2(MIX_ROUNDS);

    localparam logic [3:0] REG_KEY0 = 4'd0;
    localparam logic [3:0] REG_KEY3 = 4'd3;
    localparam logic [3:0] REG_IV0  = 4'd4;
    localparam logic [3:0] REG_IV3  = 4'd7;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FILL,
        ST_SH0, ST_SH1, ST_SH2, ST_SH3, ST_SH4,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
        ST_K0, ST_K1, ST_K2, ST_K3, ST_K4, ST_K5,
        ST_A0, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5,
        ST_WH,
        ST_OUT
    } state_t;

    typedef struct packed {
        state_t op;
        logic   load;
    } sbc_cmd_t;

    typedef struct packed {
        logic last_box;
        logic last_blk;
        logic last_round;
        logic decrypt;
    } sbc_stat_t;

endpackage
`default_nettype wire

// ===== design/swapbox_block_cipher_256.sv =====
`default_nettype none
// Encrypts or decrypts one 32-byte block per beat with a 256-bit key from the
// configuration registers. The first block after reset or after a key write
// first builds the key schedule: it loads the swap box, shuffles it and then
// runs the 262144 subkey mixing rounds. With the schedule cached, a block
// takes a keystream pass and an add layer over every byte, plus a whitening
// step, an input state and an output state. The pace is set by the single
// read port of the swap box and subkey memories, whose reads chain from one
// to the next. One block is in flight.
module swapbox_block_cipher_256
    import sbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic        use_iv,
    input  wire logic [63:0] data_word0,
    input  wire logic [63:0] data_word1,
    input  wire logic [63:0] data_word2,
    input  wire logic [63:0] data_word3,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      result_word0,
    output logic [63:0]      result_word1,
    output logic [63:0]      result_word2,
    output logic [63:0]      result_word3
);

    sbc_cmd_t  cmd;
    sbc_stat_t stat;

    sbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .stat      (stat),
        .cmd       (cmd)
    );

    sbc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .use_iv       (use_iv),
        .data_word0   (data_word0),
        .data_word1   (data_word1),
        .data_word2   (data_word2),
        .data_word3   (data_word3),
        .result_word0 (result_word0),
        .result_word1 (result_word1),
        .result_word2 (result_word2),
        .result_word3 (result_word3)
    );

endmodule
`default_nettype wire

// ===== design/sbc_dpath.sv =====
`default_nettype none
module sbc_dpath
    import sbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sbc_cmd_t    cmd,
    output sbc_stat_t        stat,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        mode,
    input  wire logic        use_iv,
    input  wire logic [63:0] data_word0,
    input  wire logic [63:0] data_word1,
    input  wire logic [63:0] data_word2,
    input  wire logic [63:0] data_word3,
    output logic [63:0]      result_word0,
    output logic [63:0]      result_word1,
    output logic [63:0]      result_word2,
    output logic [63:0]      result_word3
);

    logic [63:0]   key_reg [4];
    logic [63:0]   iv_reg [4];
    logic [7:0]    sbox_mem [256];
    logic [7:0]    msk_mem [32];
    logic [7:0]    sd_reg;
    logic [7:0]    md_reg;
    logic [7:0]    blk_reg [32];
    logic [7:0]    blk_next [32];
    logic [7:0]    n_reg;
    logic [7:0]    n_next;
    logic [7:0]    j_reg;
    logic [7:0]    j_next;
    logic [RW-1:0] r_reg;
    logic [RW-1:0] r_next;
    logic [7:0]    t0_reg;
    logic [7:0]    t0_next;
    logic [7:0]    t1_reg;
    logic [7:0]    t1_next;
    logic [7:0]    t2_reg;
    logic [7:0]    t2_next;
    logic          dec_reg;
    logic          iv_en_reg;
    logic [7:0]    key_b [32];
    logic [7:0]    sa;
    logic [4:0]    ma;
    logic          s_we;
    logic [7:0]    s_wa;
    logic [7:0]    s_wd;
    logic          m_we;
    logic [4:0]    m_wa;
    logic [7:0]    m_wd;
    logic [7:0]    kb;
    logic [7:0]    kj;
    logic [7:0]    jn;

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            key_b[i] = key_reg[i / 8][(i % 8) * 8 +: 8];
        end
    end

    always_comb
    begin
        sa = n_reg;
        ma = j_reg[4:0];
        s_we = 1'b0;
        s_wa = n_reg;
        s_wd = n_reg;
        m_we = 1'b0;
        m_wa = n_reg[4:0];
        m_wd = key_b[n_reg[4:0]];
        n_next = n_reg;
        j_next = j_reg;
        r_next = r_reg;
        t0_next = t0_reg;
        t1_next = t1_reg;
        t2_next = t2_reg;
        blk_next = blk_reg;
        kb = key_b[n_reg[4:0]];
        kj = key_b[j_reg[4:0]];
        jn = 8'd0;
        unique case (cmd.op)
            ST_FILL:
            begin
                s_we = 1'b1;
                m_we = (n_reg[7:5] == 3'd0);
                n_next = n_reg + 8'd1;
            end
            ST_SH0:
            begin
                sa = n_reg;
            end
            ST_SH1:
            begin
                t0_next = sd_reg;
                sa = j_reg;
            end
            ST_SH2:
            begin
                jn = j_reg + t0_reg + kb - key_b[kb[4:0]] + sd_reg;
                j_next = jn;
                sa = jn;
            end
            ST_SH3:
            begin
                s_we = 1'b1;
                s_wa = n_reg;
                s_wd = sd_reg;
            end
            ST_SH4:
            begin
                s_we = 1'b1;
                s_wa = j_reg;
                s_wd = t0_reg;
                n_next = n_reg + 8'd1;
                if (stat.last_box)
                begin
                    j_next = 8'd0;
                end
            end
            ST_M0:
            begin
                sa = j_reg;
            end
            ST_M1:
            begin
                sa = kj + sd_reg;
                ma = r_reg[4:0];
            end
            ST_M2:
            begin
                jn = j_reg + key_b[r_reg[4:0]] - md_reg + sd_reg - kj;
                t0_next = md_reg;
                j_next = {3'd0, jn[4:0]};
                ma = jn[4:0];
            end
            ST_M3:
            begin
                t1_next = md_reg;
                m_we = 1'b1;
                m_wa = r_reg[4:0];
                m_wd = md_reg;
                sa = r_reg[7:0];
            end
            ST_M4:
            begin
                jn = t1_reg + sd_reg - t0_reg;
                t2_next = {3'd0, jn[4:0]};
                m_we = 1'b1;
                m_wa = j_reg[4:0];
                m_wd = t0_reg;
            end
            ST_M5:
            begin
                ma = t2_reg[4:0];
            end
            ST_M6:
            begin
                m_we = 1'b1;
                m_wa = j_reg[4:0];
                m_wd = t0_reg ^ md_reg;
                r_next = r_reg + 1'b1;
                if (stat.last_round)
                begin
                    j_next = 8'd0;
                    r_next = '0;
                end
            end
            ST_K0:
            begin
                sa = n_reg;
            end
            ST_K1:
            begin
                t0_next = sd_reg;
                sa = j_reg;
            end
            ST_K2:
            begin
                t1_next = sd_reg;
                sa = t0_reg + j_reg;
            end
            ST_K3:
            begin
                jn = j_reg + t0_reg + t1_reg - sd_reg;
                j_next = jn;
                sa = jn;
            end
            ST_K4:
            begin
                sa = t0_reg + sd_reg;
            end
            ST_K5:
            begin
                blk_next[n_reg[4:0]] = blk_reg[n_reg[4:0]] ^ sd_reg;
                n_next = n_reg + 8'd1;
                if (stat.last_blk)
                begin
                    n_next = 8'd0;
                    j_next = 8'd0;
                end
            end
            ST_A0:
            begin
                sa = j_reg;
                ma = j_reg[4:0];
            end
            ST_A1:
            begin
                jn = sd_reg + md_reg;
                ma = jn[4:0];
                sa = n_reg;
            end
            ST_A2:
            begin
                t0_next = sd_reg;
                t1_next = md_reg;
                ma = n_reg[4:0];
            end
            ST_A3:
            begin
                jn = j_reg + t0_reg + md_reg - t1_reg;
                j_next = {3'd0, jn[4:0]};
                t2_next = md_reg;
                sa = {3'd0, jn[4:0]};
                ma = jn[4:0];
            end
            ST_A4:
            begin
                jn = sd_reg + md_reg;
                ma = jn[4:0];
            end
            ST_A5:
            begin
                if (dec_reg)
                begin
                    blk_next[n_reg[4:0]] = blk_reg[n_reg[4:0]] + md_reg - t2_reg;
                end
                else
                begin
                    blk_next[n_reg[4:0]] = blk_reg[n_reg[4:0]] + t2_reg - md_reg;
                end
                n_next = n_reg + 8'd1;
                if (stat.last_blk)
                begin
                    n_next = 8'd0;
                    j_next = 8'd0;
                end
            end
            ST_WH:
            begin
                if (iv_en_reg)
                begin
                    for (int i = 0; i < 32; i++)
                    begin
                        blk_next[i] = blk_reg[i] ^ iv_reg[i / 8][(i % 8) * 8 +: 8];
                    end
                end
            end
            default:
            begin
                n_next = 8'd0;
                j_next = 8'd0;
                r_next = '0;
            end
        endcase
        if (cmd.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                blk_next[i]      = data_word0[i * 8 +: 8];
                blk_next[i + 8]  = data_word1[i * 8 +: 8];
                blk_next[i + 16] = data_word2[i * 8 +: 8];
                blk_next[i + 24] = data_word3[i * 8 +: 8];
            end
        end
    end

    always_comb
    begin
        stat.last_box = (n_reg == 8'hFF);
        stat.last_blk = (n_reg == 8'h1F);
        stat.last_round = (r_reg == RW'(MIX_ROUNDS - 1));
        stat.decrypt = dec_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            sbox_mem[s_wa] <= s_wd;
        end
        sd_reg <= sbox_mem[sa];
        if (m_we)
        begin
            msk_mem[m_wa] <= m_wd;
        end
        md_reg <= msk_mem[ma];
        blk_reg <= blk_next;
        t0_reg <= t0_next;
        t1_reg <= t1_next;
        t2_reg <= t2_next;
        if (cmd.load)
        begin
            dec_reg <= mode;
            iv_en_reg <= use_iv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= 8'd0;
            j_reg <= 8'd0;
            r_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= 64'd0;
                iv_reg[i] <= 64'd0;
            end
        end
        else
        begin
            n_reg <= n_next;
            j_reg <= j_next;
            r_reg <= r_next;
            if (cfg_we && cfg_index <= REG_KEY3)
            begin
                key_reg[cfg_index[1:0]] <= cfg_data;
            end
            if (cfg_we && cfg_index >= REG_IV0 && cfg_index <= REG_IV3)
            begin
                iv_reg[cfg_index[1:0]] <= cfg_data;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            result_word0[i * 8 +: 8] = blk_reg[i];
            result_word1[i * 8 +: 8] = blk_reg[i + 8];
            result_word2[i * 8 +: 8] = blk_reg[i + 16];
            result_word3[i * 8 +: 8] = blk_reg[i + 24];
        end
    end

endmodule
`default_nettype wire

// ===== design/sbc_ctrl.sv =====
`default_nettype none
module sbc_ctrl
    import sbc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       mode,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_index,
    input  wire sbc_stat_t  stat,
    output sbc_cmd_t        cmd
);

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        in_stall = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        cmd.op = state_reg;
        cmd.load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (ready_reg)
                    begin
                        state_next = mode ? ST_WH : ST_K0;
                    end
                    else
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL: state_next = stat.last_box ? ST_SH0 : ST_FILL;
            ST_SH0: state_next = ST_SH1;
            ST_SH1: state_next = ST_SH2;
            ST_SH2: state_next = ST_SH3;
            ST_SH3: state_next = ST_SH4;
            ST_SH4: state_next = stat.last_box ? ST_M0 : ST_SH0;
            ST_M0: state_next = ST_M1;
            ST_M1: state_next = ST_M2;
            ST_M2: state_next = ST_M3;
            ST_M3: state_next = ST_M4;
            ST_M4: state_next = ST_M5;
            ST_M5: state_next = ST_M6;
            ST_M6:
            begin
                if (stat.last_round)
                begin
                    ready_next = 1'b1;
                    state_next = stat.decrypt ? ST_WH : ST_K0;
                end
                else
                begin
                    state_next = ST_M0;
                end
            end
            ST_K0: state_next = ST_K1;
            ST_K1: state_next = ST_K2;
            ST_K2: state_next = ST_K3;
            ST_K3: state_next = ST_K4;
            ST_K4: state_next = ST_K5;
            ST_K5:
            begin
                if (stat.last_blk)
                begin
                    state_next = stat.decrypt ? ST_OUT : ST_A0;
                end
                else
                begin
                    state_next = ST_K0;
                end
            end
            ST_A0: state_next = ST_A1;
            ST_A1: state_next = ST_A2;
            ST_A2: state_next = ST_A3;
            ST_A3: state_next = ST_A4;
            ST_A4: state_next = ST_A5;
            ST_A5:
            begin
                if (stat.last_blk)
                begin
                    state_next = stat.decrypt ? ST_K0 : ST_WH;
                end
                else
                begin
                    state_next = ST_A0;
                end
            end
            ST_WH: state_next = stat.decrypt ? ST_A0 : ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_we && cfg_index <= REG_KEY3)
        begin
            ready_next = 1'b0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("Result shown while input is open.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index <= REG_KEY3) |=> !ready_reg)
        else $error("Key write left the schedule marked ready.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_K0 && $past(state_reg) == ST_IDLE) |-> $past(ready_reg))
        else $error("Cipher started without a schedule.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_stall) |=> state_reg == ST_OUT)
        else $error("Result dropped under stall.");

endmodule
`default_nettype wire
